/* sv/histogram_max_rectangle_macros.svh */
// assertion macros for the histogram max rectangle rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef HISTOGRAM_MAX_RECTANGLE_MACROS_SVH
`define HISTOGRAM_MAX_RECTANGLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HMR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hmr assertion failed");

// next-cycle implication, disabled while reset is low
`define HMR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hmr assertion failed");

`endif

/* sv/hmr_pkg.sv */
// shared constants and types for the histogram max rectangle block
// depends on nothing
`default_nettype none

package hmr_pkg;

    // default parameter values
    localparam int DEF_MAX_BARS    = 1024;
    localparam int DEF_HEIGHT_BITS = 16;

    // fixed port widths
    localparam int IN_HEIGHT_BITS = 16;
    localparam int AREA_BITS      = 26;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // classification of one bar
    typedef struct packed {
        logic ignored;  // bar beyond the stack depth, dropped
        logic last;     // bar ends the histogram
    } t_bar_flags;

endpackage

`default_nettype wire

/* sv/hmr_front.sv */
// front end: accepts bars, numbers and classifies them, buffers them in a short queue
// depends on hmr_pkg
`default_nettype none

module hmr_front import hmr_pkg::*; #(
    parameter int MAX_BARS    = DEF_MAX_BARS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    localparam int CW = $clog2(MAX_BARS + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic [IN_HEIGHT_BITS-1:0] i_height,
    input  wire logic                      i_last,
    output logic                           o_q_valid,
    input  wire logic                      i_q_take,
    output logic [HEIGHT_BITS-1:0]         o_q_height,
    output logic [CW-1:0]                  o_q_pos,
    output t_bar_flags                     o_q_flags
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    logic [CW-1:0]          r_bar_cnt;
    logic [HEIGHT_BITS-1:0] w_height;
    logic                   w_accept;
    logic                   w_ignored;

    logic [HEIGHT_BITS-1:0] r_qh [QUEUE_DEPTH];
    logic [CW-1:0]          r_qp [QUEUE_DEPTH];
    t_bar_flags             r_qf [QUEUE_DEPTH];
    logic [QW-1:0]          r_wp;
    logic [QW-1:0]          r_rp;
    logic [QW:0]            r_qcnt;
    logic                   w_take;

    // keep only the height bits in use, zero-extending when the height is wider than the port
    generate
        if (HEIGHT_BITS <= IN_HEIGHT_BITS) begin : g_narrow
            assign w_height = i_height[HEIGHT_BITS-1:0];
        end else begin : g_wide
            assign w_height = {{(HEIGHT_BITS - IN_HEIGHT_BITS){1'b0}}, i_height};
        end
    endgenerate

    assign o_full    = (r_qcnt == (QW + 1)'(QUEUE_DEPTH));
    assign w_accept  = i_push && !o_full;
    assign w_ignored = (r_bar_cnt >= CW'(MAX_BARS));
    assign w_take    = i_q_take && o_q_valid;

    // bar position within the current histogram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_cnt <= '0;
        end else if (w_accept) begin
            if (i_last) begin
                r_bar_cnt <= '0;
            end else if (!w_ignored) begin
                r_bar_cnt <= r_bar_cnt + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qh[r_wp]         <= w_height;
            r_qp[r_wp]         <= r_bar_cnt;
            r_qf[r_wp].ignored <= w_ignored;
            r_qf[r_wp].last    <= i_last;
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (w_accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_take) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_accept && !w_take) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (!w_accept && w_take) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
        end
    end

    assign o_q_valid  = (r_qcnt != '0);
    assign o_q_height = r_qh[r_rp];
    assign o_q_pos    = r_qp[r_rp];
    assign o_q_flags  = r_qf[r_rp];

endmodule

`default_nettype wire

/* sv/hmr_back.sv */
// back end: monotonic stack engine, running maximum area and result register
// depends on hmr_pkg and histogram_max_rectangle_macros.svh
`default_nettype none

`include "histogram_max_rectangle_macros.svh"

module hmr_back import hmr_pkg::*; #(
    parameter int MAX_BARS    = DEF_MAX_BARS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    localparam int CW = $clog2(MAX_BARS + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    output logic                        o_q_take,
    input  wire logic [HEIGHT_BITS-1:0] i_q_height,
    input  wire logic [CW-1:0]          i_q_pos,
    input  wire t_bar_flags             i_q_flags,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output logic [AREA_BITS-1:0]        o_max_area,
    output logic                        o_overflow
);

    localparam int PW = $clog2(MAX_BARS);
    localparam int AW = HEIGHT_BITS + CW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // stack memories
    logic [HEIGHT_BITS-1:0] r_stk_h [MAX_BARS];
    logic [PW-1:0]          r_stk_p [MAX_BARS];

    logic [1:0]             r_state, n_state;
    logic [HEIGHT_BITS-1:0] r_h, n_h;
    logic [CW-1:0]          r_pos, n_pos;
    logic                   r_last, n_last;
    logic                   r_flush, n_flush;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ovf, n_ovf;
    logic [HEIGHT_BITS-1:0] r_top_h;
    logic [HEIGHT_BITS-1:0] r_rd_h;
    logic [PW-1:0]          r_rd_p;
    logic [AW-1:0]          r_prod;
    logic                   r_prod_v;
    logic [AW-1:0]          r_best;
    logic                   r_out_v;
    logic [AREA_BITS-1:0]   r_out_area;
    logic                   r_out_ovf;

    logic                   w_pop_now;
    logic                   w_push_now;
    logic                   w_out_load;
    logic [CW-1:0]          w_rd_idx;
    logic [CW-1:0]          w_span;
    logic [AREA_BITS-1:0]   w_sat;

    // entry taller than the bar under test is popped
    assign w_pop_now  = (r_state == S_CHK) && (r_cnt != '0) && (r_h < r_top_h);
    assign w_push_now = (r_state == S_CHK) && !w_pop_now && !r_flush;
    assign w_out_load = (r_state == S_OUT) && (!r_out_v || i_pop);
    assign w_rd_idx   = r_cnt - CW'(2);
    assign o_q_take   = (r_state == S_IDLE) && i_q_valid;

    // span from just above the entry below to just before the bar
    always_comb begin
        if (r_cnt == CW'(1)) begin
            w_span = r_pos;
        end else begin
            w_span = r_pos - CW'(r_rd_p) - 1'b1;
        end
    end

    // clamp the area to the result width
    generate
        if (AW > AREA_BITS) begin : g_sat
            assign w_sat = (|r_best[AW-1:AREA_BITS]) ? '1 : r_best[AREA_BITS-1:0];
        end else begin : g_nosat
            assign w_sat = AREA_BITS'(r_best);
        end
    endgenerate

    // sequencer
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_pos   = r_pos;
        n_last  = r_last;
        n_flush = r_flush;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_flags.ignored) begin
                        n_ovf = 1'b1;
                        if (i_q_flags.last) begin
                            n_h     = '0;
                            n_pos   = i_q_pos;
                            n_flush = 1'b1;
                            n_state = S_CHK;
                        end
                    end else begin
                        n_h     = i_q_height;
                        n_pos   = i_q_pos;
                        n_last  = i_q_flags.last;
                        n_flush = 1'b0;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (w_pop_now) begin
                    n_state = S_POP;
                end else if (!r_flush) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_last) begin
                        n_h     = '0;
                        n_pos   = r_pos + 1'b1;
                        n_flush = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_POP: begin
                n_cnt   = r_cnt - 1'b1;
                n_state = S_CHK;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_flush = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    // bar under test
    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_pos  <= n_pos;
        r_last <= n_last;
    end

    // stack write on push, read of the entry below the top on pop
    always_ff @(posedge i_clk) begin
        if (w_push_now) begin
            r_stk_h[r_cnt[PW-1:0]] <= r_h;
            r_stk_p[r_cnt[PW-1:0]] <= r_pos[PW-1:0];
        end
        if (w_pop_now) begin
            r_rd_h <= r_stk_h[w_rd_idx[PW-1:0]];
            r_rd_p <= r_stk_p[w_rd_idx[PW-1:0]];
        end
    end

    // cached top of stack height
    always_ff @(posedge i_clk) begin
        if (w_push_now) begin
            r_top_h <= r_h;
        end else if (r_state == S_POP) begin
            r_top_h <= r_rd_h;
        end
    end

    // area of the popped entry
    always_ff @(posedge i_clk) begin
        if (r_state == S_POP) begin
            r_prod <= AW'(r_top_h) * AW'(w_span);
        end
    end

    // running maximum, compared in the cycle after the product is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_best   <= '0;
        end else begin
            r_prod_v <= (r_state == S_POP);
            if (w_out_load) begin
                r_best <= '0;
            end else if (r_prod_v && (r_prod > r_best)) begin
                r_best <= r_prod;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (i_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_area <= w_sat;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_empty    = !r_out_v;
    assign o_max_area = r_out_area;
    assign o_overflow = r_out_ovf;

    // stack never grows past its depth
    `HMR_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_BARS))
    // a pop is always followed by a fresh compare
    `HMR_ASSERT_NXT(a_pop_then_chk, i_clk, i_rst_n, r_state == S_POP, r_state == S_CHK)
    // each pop removes exactly one entry
    `HMR_ASSERT_NXT(a_pop_dec, i_clk, i_rst_n, r_state == S_POP,
        r_cnt == CW'($past(r_cnt) - 1'b1))
    // a product is only ever pending right after a pop
    `HMR_ASSERT_IMP(a_prod_src, i_clk, i_rst_n, r_prod_v, $past(r_state) == S_POP)
    // a free result register takes the result at once
    `HMR_ASSERT_NXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && !r_out_v,
        r_out_v && (r_state == S_IDLE))

endmodule

`default_nettype wire

/* sv/histogram_max_rectangle.sv */
// flow: a bar waits in the input queue, is taken in the idle state, then compared and pushed,
// with a pop and a fresh compare for each stack entry it pops; a last bar adds the flush pops
// and a load of the result register, which waits while a previous result is still unread
// the engine takes no new bar until it is back in idle; the queue takes bars until it is full
// reset: synchronous active low i_rst_n empties queue, stack and result; no clearing pass
`default_nettype none

module histogram_max_rectangle import hmr_pkg::*; #(
    parameter int MAX_BARS    = DEF_MAX_BARS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic [IN_HEIGHT_BITS-1:0] i_height,
    input  wire logic                      i_last,
    output logic                           o_empty,
    input  wire logic                      i_pop,
    output logic [AREA_BITS-1:0]           o_max_area,
    output logic                           o_overflow
);

    localparam int CW = $clog2(MAX_BARS + 1);

    logic                   w_q_valid;
    logic                   w_q_take;
    logic [HEIGHT_BITS-1:0] w_q_height;
    logic [CW-1:0]          w_q_pos;
    t_bar_flags             w_q_flags;

    // bar intake and queue
    hmr_front #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_height   (i_height),
        .i_last     (i_last),
        .o_q_valid  (w_q_valid),
        .i_q_take   (w_q_take),
        .o_q_height (w_q_height),
        .o_q_pos    (w_q_pos),
        .o_q_flags  (w_q_flags)
    );

    // stack engine and result
    hmr_back #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_take   (w_q_take),
        .i_q_height (w_q_height),
        .i_q_pos    (w_q_pos),
        .i_q_flags  (w_q_flags),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_max_area (o_max_area),
        .o_overflow (o_overflow)
    );

endmodule

`default_nettype wire
